// ===== sv/kbf_pkg.sv =====
`timescale 1ns / 1ps
package kbf_pkg;
   localparam int STORE_BYTES = 65536;
   localparam int ADDR_W = 16;
   localparam int MAX_GROUP = 15;
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_WRITE  = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;
   localparam logic [1:0] CSR_FILTER_BYTES = 2'd0;
   localparam logic [1:0] CSR_HASHES       = 2'd1;
   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] address;
      logic [2:0]        bit_sel;
      logic [7:0]        data;
      logic              read_end;
   } op_type;
endpackage

// ===== sv/kbf_front.sv =====
`timescale 1ns / 1ps
// Reduces an insert or query hash modulo 8*filter_bytes with one restoring subtract per cycle.
module kbf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          action,
   input  logic [63:0]         kmer_hash,
   input  logic [15:0]         byte_address,
   input  logic [7:0]          byte_data,
   input  logic                read_end,
   input  logic [16:0]         filter_bytes,
   input  logic                q_full,
   output logic                q_push,
   output kbf_pkg::op_type     q_data
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [6:0]  count_ff, count_in;
   logic [63:0] hash_ff, hash_in;
   logic [19:0] rem_ff, rem_in;
   logic [19:0] modulus_ff, modulus_in;
   kbf_pkg::op_type op_ff, op_in;
   logic [16:0] fb_eff;
   logic [20:0] shifted;

   always_comb begin
      fb_eff = filter_bytes;
      if (fb_eff == 17'd0) fb_eff = 17'd1;
      if (fb_eff > 17'(kbf_pkg::STORE_BYTES)) fb_eff = 17'(kbf_pkg::STORE_BYTES);
   end

   assign busy = (state_ff != ST_IDLE);
   assign shifted = {rem_ff, hash_ff[63]};
   assign q_push = (state_ff == ST_PUSH) && !q_full;
   assign q_data = op_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      hash_in = hash_ff;
      rem_in = rem_ff;
      modulus_in = modulus_ff;
      op_in = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in.action = action;
               op_in.address = byte_address;
               op_in.bit_sel = 3'd0;
               op_in.data = byte_data;
               op_in.read_end = read_end;
               hash_in = kmer_hash;
               rem_in = 20'd0;
               modulus_in = {fb_eff, 3'b000};
               count_in = 7'd0;
               if (action == kbf_pkg::ACT_INSERT || action == kbf_pkg::ACT_QUERY) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_DIV: begin
            if (shifted >= {1'b0, modulus_ff}) begin
               rem_in = 20'(shifted - {1'b0, modulus_ff});
            end else begin
               rem_in = shifted[19:0];
            end
            hash_in = {hash_ff[62:0], 1'b0};
            count_in = 7'(count_ff + 7'd1);
            if (count_ff == 7'd63) begin
               state_in = ST_PUSH;
               op_in.address = rem_in[18:3];
               op_in.bit_sel = rem_in[2:0];
            end
         end
         ST_PUSH: begin
            if (!q_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      hash_ff <= hash_in;
      rem_ff <= rem_in;
      modulus_ff <= modulus_in;
      op_ff <= op_in;
   end
endmodule

// ===== sv/kbf_queue.sv =====
`timescale 1ns / 1ps
module kbf_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  kbf_pkg::op_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output kbf_pkg::op_type pop_data
);
   kbf_pkg::op_type slot_ff [2];
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] fill_ff, fill_in;

   assign full = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff ^ push;
      rd_in = rd_ff ^ pop;
      fill_in = 2'(fill_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) slot_ff[wr_ff] <= push_data;
   end
endmodule

// ===== sv/kbf_back.sv =====
`timescale 1ns / 1ps
// Clears the store after reset, then runs each operation as a store read and an execute step.
module kbf_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  kbf_pkg::op_type q_data,
   output logic            q_pop,
   input  logic [3:0]      hashes_per_kmer,
   output logic            clearing,
   output logic            idle,
   output logic            rsp_valid,
   output logic            rsp_result_kind,
   output logic [15:0]     rsp_kmer_hit_count,
   output logic [7:0]      rsp_store_byte
);
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EXEC  = 2'd3;

   logic [7:0] mem [kbf_pkg::STORE_BYTES];
   logic [7:0] rdata_ff;
   logic [1:0] state_ff, state_in;
   logic [kbf_pkg::ADDR_W-1:0] clr_ff, clr_in;
   kbf_pkg::op_type op_ff, op_in;
   logic [3:0] pos_ff, pos_in, hits_ff, hits_in;
   logic [15:0] total_ff, total_in;
   logic we;
   logic [kbf_pkg::ADDR_W-1:0] waddr;
   logic [7:0] wdata;
   logic rv_ff, rv_in, rk_ff, rk_in;
   logic [15:0] rc_ff, rc_in;
   logic [7:0] rb_ff, rb_in;
   logic [3:0] grp;
   logic [7:0] mask;
   logic [3:0] p1, h1;

   assign clearing = (state_ff == ST_CLEAR);
   assign idle = (state_ff == ST_IDLE) && !q_valid;
   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = rv_ff;
   assign rsp_result_kind = rk_ff;
   assign rsp_kmer_hit_count = rc_ff;
   assign rsp_store_byte = rb_ff;

   always_comb begin
      grp = hashes_per_kmer;
      if (grp == 4'd0) grp = 4'd1;
      if (grp > 4'(kbf_pkg::MAX_GROUP)) grp = 4'(kbf_pkg::MAX_GROUP);
      mask = 8'd1 << op_ff.bit_sel;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      pos_in = pos_ff;
      hits_in = hits_ff;
      total_in = total_ff;
      we = 1'b0;
      waddr = op_ff.address;
      wdata = rdata_ff | mask;
      rv_in = 1'b0;
      rk_in = kbf_pkg::KIND_COUNT;
      rc_in = 16'd0;
      rb_in = 8'd0;
      p1 = 4'(pos_ff + 4'd1);
      h1 = ((rdata_ff & mask) != 8'd0) ? 4'(hits_ff + 4'd1) : hits_ff;
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            waddr = clr_ff;
            wdata = 8'd0;
            clr_in = clr_ff + 16'd1;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               op_in = q_data;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (op_ff.action)
               kbf_pkg::ACT_INSERT: we = 1'b1;
               kbf_pkg::ACT_WRITE: begin
                  we = 1'b1;
                  wdata = op_ff.data;
               end
               kbf_pkg::ACT_READ: begin
                  rv_in = 1'b1;
                  rk_in = kbf_pkg::KIND_BYTE;
                  rb_in = rdata_ff;
               end
               kbf_pkg::ACT_QUERY: begin
                  pos_in = p1;
                  hits_in = h1;
                  if (p1 >= grp) begin
                     if (h1 >= p1 && total_ff != 16'hFFFF) total_in = 16'(total_ff + 16'd1);
                     pos_in = 4'd0;
                     hits_in = 4'd0;
                  end
                  if (op_ff.read_end) begin
                     rv_in = 1'b1;
                     rc_in = total_in;
                     total_in = 16'd0;
                     pos_in = 4'd0;
                     hits_in = 4'd0;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[op_ff.address];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         pos_ff <= 4'd0;
         hits_ff <= 4'd0;
         total_ff <= 16'd0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pos_ff <= pos_in;
         hits_ff <= hits_in;
         total_ff <= total_in;
         rv_ff <= rv_in;
      end
      op_ff <= op_in;
      rk_ff <= rk_in;
      rc_ff <= rc_in;
      rb_ff <= rb_in;
   end
endmodule

// ===== sv/kmer_bloom_filter.sv =====
`timescale 1ns / 1ps
// Insert and query transactions hold busy high after they are accepted while the front
// part reduces the hash bit-serially and hands the result to the queue, so a new one
// cannot be accepted until then. Byte write and read transactions pass through the
// front part without reduction, stalling there while the queue is full. The back part
// runs every transaction through its store read and execute states, writes back for
// inserts and byte writes, and takes the next transaction only once idle. A result is
// registered onto rsp_valid from the execute state for a byte read or a read-end query.
// After reset the store is cleared, during which busy stays high.
// csr_ready is low while the store is cleared or any transaction is in flight.
// The receiver cannot stall: each result appears for one cycle with rsp_valid.
module kmer_bloom_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_kmer_hash,
   input  logic [15:0] req_byte_address,
   input  logic [7:0]  req_byte_data,
   input  logic        req_read_end,
   output logic        rsp_valid,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_kmer_hit_count,
   output logic [7:0]  rsp_store_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);
   logic [16:0] filter_bytes_ff;
   logic [3:0] hashes_ff;
   logic front_busy, q_push, q_full, q_valid, q_pop, clearing, back_idle;
   kbf_pkg::op_type push_data, pop_data;

   assign busy = front_busy || clearing;
   assign csr_ready = !front_busy && back_idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bytes_ff <= 17'd65536;
         hashes_ff <= 4'd1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == kbf_pkg::CSR_FILTER_BYTES) filter_bytes_ff <= csr_data;
         else if (csr_index == kbf_pkg::CSR_HASHES) hashes_ff <= csr_data[3:0];
      end
   end

   kbf_front u_front (
      .clock, .reset, .start(start && !clearing), .busy(front_busy),
      .action(req_action), .kmer_hash(req_kmer_hash),
      .byte_address(req_byte_address), .byte_data(req_byte_data),
      .read_end(req_read_end), .filter_bytes(filter_bytes_ff),
      .q_full, .q_push, .q_data(push_data)
   );

   kbf_queue u_queue (
      .clock, .reset, .push(q_push), .push_data, .full(q_full),
      .pop(q_pop), .not_empty(q_valid), .pop_data
   );

   kbf_back u_back (
      .clock, .reset, .q_valid, .q_data(pop_data), .q_pop,
      .hashes_per_kmer(hashes_ff), .clearing, .idle(back_idle),
      .rsp_valid, .rsp_result_kind, .rsp_kmer_hit_count, .rsp_store_byte
   );
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   typedef struct {
      logic [1:0]  action;
      logic [63:0] hash;
      logic [15:0] addr;
      logic [7:0]  data;
      logic        last;
   } bloom_op_type;

   typedef struct {
      logic        kind;
      logic [15:0] count;
      logic [7:0]  store_byte;
   } bloom_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = kbf_pkg::ACT_INSERT;
   logic [63:0] req_kmer_hash = '0;
   logic [15:0] req_byte_address = '0;
   logic [7:0]  req_byte_data = '0;
   logic        req_read_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_result_kind;
   logic [15:0] rsp_kmer_hit_count;
   logic [7:0]  rsp_store_byte;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = kbf_pkg::CSR_FILTER_BYTES;
   logic [16:0] csr_data = '0;

   kmer_bloom_filter DUT (.*);

   always #5 clock = ~clock;

   bloom_op_type      pending_ops[$];
   bloom_result_type  expected_results[$];
   bloom_op_type      held_op;
   longint unsigned   hash_pool[$];
   logic [7:0]        shadow_store [0:kbf_pkg::STORE_BYTES-1];
   logic [16:0]       shadow_filter_bytes = 17'd65536;
   logic [3:0]        shadow_hashes = 4'd1;
   int                group_pos = 0;
   int                group_hits = 0;
   int                read_hits = 0;
   int                sender_idle_pct = 21;
   int                errors = 0;
   int                items_sent = 0;
   int                results_checked = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   task automatic bloom_predict(input bloom_op_type op);
      longint unsigned  fb;
      longint unsigned  bitno;
      int               grp;
      int               idx;
      logic [7:0]       mask;
      bloom_result_type r;
      fb = shadow_filter_bytes;
      if (fb == 0) fb = 1;
      if (fb > kbf_pkg::STORE_BYTES) fb = kbf_pkg::STORE_BYTES;
      grp = (shadow_hashes == 0) ? 1 : shadow_hashes;
      if (grp > kbf_pkg::MAX_GROUP) grp = kbf_pkg::MAX_GROUP;
      bitno = op.hash % (fb * 8);
      idx = int'(bitno >> 3);
      mask = 8'b1 << bitno[2:0];
      case (op.action)
         kbf_pkg::ACT_INSERT: shadow_store[idx] = shadow_store[idx] | mask;
         kbf_pkg::ACT_WRITE: shadow_store[op.addr] = op.data;
         kbf_pkg::ACT_READ: begin
            r.kind = kbf_pkg::KIND_BYTE;
            r.count = '0;
            r.store_byte = shadow_store[op.addr];
            expected_results = {expected_results, r};
         end
         default: begin
            group_pos++;
            if ((shadow_store[idx] & mask) != 0) group_hits++;
            if (group_pos >= grp) begin
               if (group_hits >= group_pos && read_hits < 65535) read_hits++;
               group_pos = 0;
               group_hits = 0;
            end
            if (op.last) begin
               r.kind = kbf_pkg::KIND_COUNT;
               r.count = read_hits[15:0];
               r.store_byte = '0;
               expected_results = {expected_results, r};
               read_hits = 0;
               group_pos = 0;
               group_hits = 0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            bloom_predict(held_op);
            items_sent++;
         end
         if (!start || !busy) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               held_op = pending_ops.pop_front();
               req_action <= held_op.action;
               req_kmer_hash <= held_op.hash;
               req_byte_address <= held_op.addr;
               req_byte_data <= held_op.data;
               req_read_end <= held_op.last;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      bloom_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result count", results_checked + 1, results_checked);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_result_kind !== want.kind)
               report_mismatch("result_kind", rsp_result_kind, want.kind);
            if (rsp_kmer_hit_count !== want.count)
               report_mismatch("kmer_hit_count", rsp_kmer_hit_count, want.count);
            if (rsp_store_byte !== want.store_byte)
               report_mismatch("store_byte", rsp_store_byte, want.store_byte);
         end
      end
   end

   task automatic push_op(input logic [1:0] action, input logic [63:0] hash,
                          input logic [15:0] addr, input logic [7:0] data, input logic last);
      bloom_op_type op;
      op.action = action;
      op.hash = hash;
      op.addr = addr;
      op.data = data;
      op.last = last;
      pending_ops = {pending_ops, op};
   endtask

   function automatic logic [63:0] random_hash();
      return {$urandom, $urandom};
   endfunction

   // Waits until every queued transaction has been taken and answered, then lets
   // an insert still in flight finish.
   task automatic drain();
      while (pending_ops.size() > 0 || start || expected_results.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [16:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      if (index == kbf_pkg::CSR_FILTER_BYTES) shadow_filter_bytes = value;
      else if (index == kbf_pkg::CSR_HASHES) shadow_hashes = value[3:0];
   endtask

   task automatic random_phase(input int n_items);
      int              made;
      int              pick;
      int              len;
      int              n_ins;
      logic [63:0]     h;
      made = 0;
      while (made < n_items) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            push_op(2'($urandom_range(3)), random_hash(), 16'($urandom), 8'($urandom),
                    1'($urandom_range(1)));
            made++;
         end else if (pick < 25) begin
            push_op($urandom_range(1) ? kbf_pkg::ACT_WRITE : kbf_pkg::ACT_READ, random_hash(),
                    $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(63)),
                    8'($urandom), 1'($urandom_range(1)));
            made++;
         end else begin
            n_ins = $urandom_range(4, 1);
            repeat (n_ins) begin
               h = random_hash();
               hash_pool = {hash_pool, h};
               push_op(kbf_pkg::ACT_INSERT, h, 16'($urandom), 8'($urandom),
                       1'($urandom_range(1)));
            end
            if (hash_pool.size() > 64) hash_pool = hash_pool[hash_pool.size()-64:$];
            len = $urandom_range(3 * (shadow_hashes == 0 ? 1 : shadow_hashes), 1);
            for (int i = 0; i < len; i++) begin
               h = ($urandom_range(9) < 7) ? hash_pool[$urandom_range(hash_pool.size() - 1)]
                                          : random_hash();
               push_op(kbf_pkg::ACT_QUERY, h, 16'($urandom), 8'($urandom), i == len - 1);
            end
            made += n_ins + len;
         end
      end
      drain();
   endtask

   initial begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push_op(kbf_pkg::ACT_INSERT, 64'd0, 16'hFFFF, 8'hFF, 1'b1);
      push_op(kbf_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 8'd0, 1'b0);
      push_op(kbf_pkg::ACT_QUERY, 64'd0, 16'd0, 8'd0, 1'b0);
      push_op(kbf_pkg::ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 8'd0, 1'b1);
      push_op(kbf_pkg::ACT_QUERY, 64'h1234_5678_9ABC_DEF0, 16'd0, 8'd0, 1'b1);
      push_op(kbf_pkg::ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1);
      push_op(kbf_pkg::ACT_READ, 64'd0, 16'hFFFF, 8'd0, 1'b1);
      push_op(kbf_pkg::ACT_READ, 64'd0, 16'd0, 8'hFF, 1'b0);
      push_op(kbf_pkg::ACT_WRITE, 64'd0, 16'd0, 8'hA5, 1'b0);
      push_op(kbf_pkg::ACT_READ, 64'd0, 16'd0, 8'd0, 1'b0);
      push_op(kbf_pkg::ACT_READ, 64'd0, 16'h8000, 8'd0, 1'b0);
      drain();

      csr_write(kbf_pkg::CSR_HASHES, 17'd3);
      push_op(kbf_pkg::ACT_QUERY, 64'd0, 16'd0, 8'd0, 1'b0);
      push_op(kbf_pkg::ACT_QUERY, 64'd0, 16'd0, 8'd0, 1'b1);
      push_op(kbf_pkg::ACT_QUERY, 64'd0, 16'd0, 8'd0, 1'b0);
      push_op(kbf_pkg::ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 8'd0, 1'b0);
      drain();
      csr_write(kbf_pkg::CSR_HASHES, 17'd1);
      push_op(kbf_pkg::ACT_QUERY, 64'd0, 16'd0, 8'd0, 1'b1);
      drain();
      csr_write(kbf_pkg::CSR_FILTER_BYTES, 17'd0);
      csr_write(kbf_pkg::CSR_HASHES, 17'd0);
      push_op(kbf_pkg::ACT_QUERY, 64'd8, 16'd0, 8'd0, 1'b0);
      push_op(kbf_pkg::ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFF8, 16'd0, 8'd0, 1'b1);
      drain();

      sender_idle_pct = 21;
      csr_write(kbf_pkg::CSR_FILTER_BYTES, 17'd4);
      csr_write(kbf_pkg::CSR_HASHES, 17'd3);
      random_phase(80);
      csr_write(kbf_pkg::CSR_FILTER_BYTES, 17'd1);
      csr_write(kbf_pkg::CSR_HASHES, 17'd15);
      random_phase(70);
      sender_idle_pct = 66;
      csr_write(kbf_pkg::CSR_FILTER_BYTES, 17'h1FFFF);
      csr_write(kbf_pkg::CSR_HASHES, 17'd0);
      random_phase(80);
      sender_idle_pct = 0;
      csr_write(kbf_pkg::CSR_FILTER_BYTES, 17'd0);
      csr_write(kbf_pkg::CSR_HASHES, 17'd2);
      random_phase(80);
      csr_write(kbf_pkg::CSR_FILTER_BYTES, 17'd37);
      csr_write(kbf_pkg::CSR_HASHES, 17'd1);
      random_phase(80);

      $display("run covered %0d transactions over several filter and group sizes", items_sent);
      $display("%0d results were compared, %0d mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
   end
endmodule
